### hw/rtl/mglcd_pkg.sv
// Shared types and constants for the monochrome graphic LCD frame controller.
// Holds the command codes, the controller/datapath command and status
// structs and the 6x8 font. No dependencies.
`default_nettype none

package mglcd_pkg;

  typedef enum logic [2:0] {
    REQ_SET_PIXEL   = 3'd0,
    REQ_CLEAR_PIXEL = 3'd1,
    REQ_CLEAR_SCRN  = 3'd2,
    REQ_PUT_CHAR    = 3'd3,
    REQ_REFRESH     = 3'd4,
    REQ_SET_CURSOR  = 3'd5,
    REQ_PLOT        = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    RD_PIXEL   = 2'd0,
    RD_PLOT    = 2'd1,
    RD_REFRESH = 2'd2
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_ZERO  = 2'd0,
    WR_SET   = 2'd1,
    WR_CLR   = 2'd2,
    WR_GLYPH = 2'd3
  } wr_sel_t;

  typedef enum logic [1:0] {
    PUSH_CHAR_ERR = 2'd0,
    PUSH_GLYPH    = 2'd1,
    PUSH_PLOT     = 2'd2,
    PUSH_PLOT_ERR = 2'd3
  } push_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      latch;
    logic      cursor_load;
    logic      cursor_adv;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    logic      push;
    push_sel_t push_sel;
  } mglcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pix_ok;
    logic code_ok;
    logic plot_ok;
    logic glyph_last;
    logic refresh_issued;
    logic clear_last;
    logic q_space;
    logic rd_credit;
    logic rd_pending;
  } mglcd_stat_t;

  typedef struct packed {
    logic       half;
    logic [2:0] page;
    logic [5:0] column;
    logic [7:0] data;
    logic       last;
    logic       error;
  } beat_t;

  localparam int HALF_COLUMNS = 64;
  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd127;

  // Division by ten for values below 1029: (v * 205) >> 11.
  localparam int RECIP_MUL   = 205;
  localparam int RECIP_SHIFT = 11;
  localparam int ROW_SCALE   = 10;

  // One entry per printable code starting at CHAR_FIRST; column 0 in the top byte.
  localparam logic [47:0] FONT_ROM [96] = '{
    48'h000000000000, 48'h0000065F0600, 48'h000703000703, 48'h00247E247E24,
    48'h00242B6A1200, 48'h006313086463, 48'h003649562050, 48'h000007030000,
    48'h00003E410000, 48'h0000413E0000, 48'h00083E1C3E08, 48'h0008083E0808,
    48'h0000E0600000, 48'h000808080808, 48'h000060600000, 48'h002010080402,
    48'h003E5149453E, 48'h0000427F4000, 48'h006251494946, 48'h002249494936,
    48'h001814127F10, 48'h002F49494931, 48'h003C4A494930, 48'h000171090503,
    48'h003649494936, 48'h00064949291E, 48'h00006C6C0000, 48'h0000EC6C0000,
    48'h000814224100, 48'h002424242424, 48'h000041221408, 48'h000201590906,
    48'h003E415D551E, 48'h007E1111117E, 48'h007F49494936, 48'h003E41414122,
    48'h007F4141413E, 48'h007F49494941, 48'h007F09090901, 48'h003E4149497A,
    48'h007F0808087F, 48'h0000417F4100, 48'h00304040403F, 48'h007F08142241,
    48'h007F40404040, 48'h007F0204027F, 48'h007F0204087F, 48'h003E4141413E,
    48'h007F09090906, 48'h003E4151215E, 48'h007F09091966, 48'h002649494932,
    48'h0001017F0101, 48'h003F4040403F, 48'h001F2040201F, 48'h003F403C403F,
    48'h006314081463, 48'h000708700807, 48'h007149454300, 48'h00007F414100,
    48'h000204081020, 48'h000041417F00, 48'h000402010204, 48'h808080808080,
    48'h000003070000, 48'h002054545478, 48'h007F44444438, 48'h003844444428,
    48'h00384444447F, 48'h003854545408, 48'h00087E090900, 48'h0018A4A4A47C,
    48'h007F04047800, 48'h0000007D4000, 48'h004080847D00, 48'h007F10284400,
    48'h0000007F4000, 48'h007C04180478, 48'h007C04047800, 48'h003844444438,
    48'h00FC44444438, 48'h0038444444FC, 48'h004478440408, 48'h000854545420,
    48'h00043E442400, 48'h003C40207C00, 48'h001C2040201C, 48'h003C6030603C,
    48'h006C10106C00, 48'h009CA0603C00, 48'h006454544C00, 48'h00083E414100,
    48'h000000770000, 48'h000041413E08, 48'h000201020100, 48'h003C2623263C
  };

endpackage

`default_nettype wire

### hw/rtl/mglcd_ctrl.sv
// Command sequencer of the monochrome graphic LCD frame controller.
// Drives the datapath through mglcd_cmd_t and reads mglcd_stat_t (mglcd_pkg).
`default_nettype none

module mglcd_ctrl
  import mglcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire mglcd_stat_t stat,
  output mglcd_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIXEL,
    ST_RMW,
    ST_CHAR,
    ST_REFRESH,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_PLOT
  } state_t;

  state_t  state_r, state_nxt;
  wr_sel_t rmw_sel_r, rmw_sel_nxt;
  logic    rmw_push_r, rmw_push_nxt;
  logic    accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    rmw_sel_nxt  = rmw_sel_r;
    rmw_push_nxt = rmw_push_r;
    cmd          = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_ZERO;
        cmd.cnt_inc = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.latch   = 1'b1;
          cmd.cnt_clr = 1'b1;
          case (req_t'(in_req_type))
            REQ_SET_PIXEL: begin
              rmw_sel_nxt  = WR_SET;
              rmw_push_nxt = 1'b0;
              state_nxt    = ST_PIXEL;
            end
            REQ_CLEAR_PIXEL: begin
              rmw_sel_nxt  = WR_CLR;
              rmw_push_nxt = 1'b0;
              state_nxt    = ST_PIXEL;
            end
            REQ_CLEAR_SCRN: state_nxt = ST_CLEAR;
            REQ_PUT_CHAR:   state_nxt = ST_CHAR;
            REQ_REFRESH:    state_nxt = ST_REFRESH;
            REQ_SET_CURSOR: cmd.cursor_load = 1'b1;
            REQ_PLOT: begin
              rmw_sel_nxt  = WR_SET;
              rmw_push_nxt = 1'b1;
              state_nxt    = ST_MUL1;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PIXEL: begin
        if (stat.pix_ok) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PIXEL;
          state_nxt  = ST_RMW;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RMW: begin
        if (!rmw_push_r || stat.q_space) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = rmw_sel_r;
          cmd.push     = rmw_push_r;
          cmd.push_sel = PUSH_PLOT;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CHAR: begin
        if (stat.q_space) begin
          cmd.push = 1'b1;
          if (!stat.code_ok) begin
            cmd.push_sel = PUSH_CHAR_ERR;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.push_sel   = PUSH_GLYPH;
            cmd.wr_en      = 1'b1;
            cmd.wr_sel     = WR_GLYPH;
            cmd.cursor_adv = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (stat.glyph_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_REFRESH: begin
        if (!stat.refresh_issued) begin
          if (stat.rd_credit) begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_REFRESH;
            cmd.cnt_inc = 1'b1;
          end
        end else if (!stat.rd_pending) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_PLOT;
      ST_PLOT: begin
        if (!stat.plot_ok) begin
          if (stat.q_space) begin
            cmd.push     = 1'b1;
            cmd.push_sel = PUSH_PLOT_ERR;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PLOT;
          state_nxt  = ST_RMW;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      rmw_sel_r  <= WR_SET;
      rmw_push_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rmw_sel_r  <= rmw_sel_nxt;
      rmw_push_r <= rmw_push_nxt;
    end
  end

  // An accepted refresh command stalls intake once it has been taken.
  a_refresh_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_REFRESH) |=> in_stall)
    else $error("refresh command did not hold off intake");

  // The clearing sweep never overlaps a store read.
  a_clear_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!cmd.rd_en && in_stall))
    else $error("read or intake during clearing sweep");

  // Glyph writes and cursor steps always go out together with a beat.
  a_glyph_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cursor_adv |-> (cmd.push && cmd.push_sel == PUSH_GLYPH && stat.q_space))
    else $error("cursor stepped without a glyph beat");

endmodule

`default_nettype wire

### hw/rtl/mglcd_dp.sv
// Datapath of the monochrome graphic LCD frame controller: frame store,
// cursor, plot arithmetic, refresh read pipeline and a two-beat output queue.
// Uses mglcd_pkg; sequenced by mglcd_ctrl.
`default_nettype none

module mglcd_dp
  import mglcd_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64,
  parameter int GLYPH_WIDTH    = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire mglcd_cmd_t  cmd,
  output mglcd_stat_t      stat,
  input  wire logic [6:0]  in_pixel_x,
  input  wire logic [5:0]  in_pixel_y,
  input  wire logic [7:0]  in_text_char,
  input  wire logic [7:0]  in_sample_value,
  input  wire logic [2:0]  in_target_page,
  input  wire logic        in_target_half,
  input  wire logic [5:0]  in_target_column,
  input  wire logic [7:0]  gain_tenths,
  input  wire logic [7:0]  offset_tenths,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_half,
  output logic [2:0]       out_page,
  output logic [5:0]       out_column,
  output logic [7:0]       out_data,
  output logic             out_last,
  output logic             out_cmd_error
);

  localparam int XW         = $clog2(SCREEN_COLUMNS);
  localparam int AW         = XW + 3;
  localparam int DEPTH      = SCREEN_COLUMNS * 8;
  localparam int PAGE_COUNT = SCREEN_ROWS / 8;
  localparam int PLOT_LIMIT = SCREEN_ROWS * ROW_SCALE;

  function automatic logic [AW-1:0] mk_addr(logic [6:0] x, logic [2:0] pg);
    return {XW'(x), pg};
  endfunction

  function automatic logic on_screen(logic [6:0] x, logic [2:0] pg);
    return (9'(x) < 9'(SCREEN_COLUMNS)) && (4'(pg) < 4'(PAGE_COUNT));
  endfunction

  function automatic logic code_valid(logic [7:0] code);
    return (code >= CHAR_FIRST) && (code <= CHAR_LAST);
  endfunction

  // Latched command fields
  logic [6:0]  px_r;
  logic [5:0]  py_r;
  logic [7:0]  code_r;
  logic [7:0]  smp_r;
  logic [2:0]  tpage_r;
  logic        thalf_r;
  logic [47:0] glyph_r;
  logic [47:0] glyph_lookup;
  logic [6:0]  font_idx;
  logic        glyph_shift;

  // Cursor
  logic [5:0] cur_col_r;
  logic       cur_half_r;
  logic [2:0] cur_page_r;
  logic [6:0] cur_x;

  // Plot arithmetic
  logic [15:0] prod_r;
  logic [15:0] sum_r;
  logic [17:0] recip;
  logic [5:0]  quot_r;
  logic        plot_ok_r;

  // Store access
  logic [AW-1:0] cnt_r;
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] raddr, waddr, rmw_addr_r;
  logic [7:0]    wdata, rd_mask, mask_r;
  logic          mem_we;

  // Refresh read pipeline
  logic       pend_r;
  logic [5:0] pend_col_r;
  logic       pend_last_r;
  logic       pend_vis_r;

  // Output queue
  beat_t      q_mem [2];
  logic       q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  logic       q_push, q_pop;
  beat_t      push_beat;
  logic [2:0] q_level;

  assign font_idx     = 7'(in_text_char - CHAR_FIRST);
  assign glyph_lookup = code_valid(in_text_char) ? FONT_ROM[font_idx] : '0;
  assign glyph_shift  = cmd.push && (cmd.push_sel == PUSH_GLYPH);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px_r    <= in_pixel_x;
      py_r    <= in_pixel_y;
      code_r  <= in_text_char;
      smp_r   <= in_sample_value;
      tpage_r <= in_target_page;
      thalf_r <= in_target_half;
      glyph_r <= glyph_lookup;
    end else if (glyph_shift) begin
      // Columns beyond the font width come out as zero.
      glyph_r <= {glyph_r[39:0], 8'h00};
    end
  end

  assign cur_x = {cur_half_r, cur_col_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_half_r <= 1'b0;
      cur_page_r <= '0;
    end else if (cmd.cursor_load) begin
      cur_col_r  <= in_target_column;
      cur_half_r <= in_target_half;
      cur_page_r <= in_target_page;
    end else if (cmd.cursor_adv) begin
      cur_col_r <= cur_col_r + 6'd1;
      if (cur_col_r == 6'(HALF_COLUMNS - 1)) begin
        cur_half_r <= ~cur_half_r;
        if (cur_half_r) begin
          cur_page_r <= cur_page_r + 3'd1;
        end
      end
    end
  end

  // Row = (sample * gain + offset) / 10, one register after each product.
  assign recip = 18'(sum_r[9:0]) * 18'(RECIP_MUL);

  always_ff @(posedge clk) begin
    prod_r    <= 16'(smp_r) * 16'(gain_tenths);
    sum_r     <= prod_r + 16'(offset_tenths);
    quot_r    <= 6'(recip >> RECIP_SHIFT);
    plot_ok_r <= (sum_r < 16'(PLOT_LIMIT)) && (9'(px_r) < 9'(SCREEN_COLUMNS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_PIXEL: begin
        raddr   = mk_addr(px_r, py_r[5:3]);
        rd_mask = 8'd1 << py_r[2:0];
      end
      RD_PLOT: begin
        raddr   = mk_addr(px_r, quot_r[5:3]);
        rd_mask = 8'd1 << quot_r[2:0];
      end
      RD_REFRESH: begin
        raddr   = mk_addr({thalf_r, cnt_r[5:0]}, tpage_r);
        rd_mask = 8'd0;
      end
      default: begin
        raddr   = '0;
        rd_mask = 8'd0;
      end
    endcase
  end

  always_comb begin
    mem_we = cmd.wr_en;
    case (cmd.wr_sel)
      WR_ZERO: begin
        waddr = cnt_r;
        wdata = 8'd0;
      end
      WR_SET: begin
        waddr = rmw_addr_r;
        wdata = rdata_r | mask_r;
      end
      WR_CLR: begin
        waddr = rmw_addr_r;
        wdata = rdata_r & ~mask_r;
      end
      WR_GLYPH: begin
        waddr  = mk_addr(cur_x, cur_page_r);
        wdata  = glyph_r[47:40];
        mem_we = cmd.wr_en && on_screen(cur_x, cur_page_r);
      end
      default: begin
        waddr = '0;
        wdata = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en && cmd.rd_sel != RD_REFRESH) begin
      rmw_addr_r <= raddr;
      mask_r     <= rd_mask;
    end
    if (cmd.rd_en && cmd.rd_sel == RD_REFRESH) begin
      pend_col_r  <= cnt_r[5:0];
      pend_last_r <= (cnt_r[5:0] == 6'(HALF_COLUMNS - 1));
      pend_vis_r  <= on_screen({thalf_r, cnt_r[5:0]}, tpage_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.rd_en && (cmd.rd_sel == RD_REFRESH);
    end
  end

  // Beat assembly: refresh data arrives from the read pipeline, the rest
  // comes straight from the sequencer.
  always_comb begin
    push_beat = '0;
    if (pend_r) begin
      push_beat.half   = thalf_r;
      push_beat.page   = tpage_r;
      push_beat.column = pend_col_r;
      push_beat.data   = pend_vis_r ? rdata_r : 8'd0;
      push_beat.last   = pend_last_r;
    end else begin
      case (cmd.push_sel)
        PUSH_CHAR_ERR: begin
          push_beat.half   = cur_half_r;
          push_beat.page   = cur_page_r;
          push_beat.column = cur_col_r;
          push_beat.last   = 1'b1;
          push_beat.error  = 1'b1;
        end
        PUSH_GLYPH: begin
          push_beat.half   = cur_half_r;
          push_beat.page   = cur_page_r;
          push_beat.column = cur_col_r;
          push_beat.data   = glyph_r[47:40];
          push_beat.last   = (cnt_r == AW'(GLYPH_WIDTH - 1));
        end
        PUSH_PLOT: begin
          push_beat.half   = px_r[6];
          push_beat.page   = quot_r[5:3];
          push_beat.column = px_r[5:0];
          push_beat.data   = rdata_r | mask_r;
          push_beat.last   = 1'b1;
        end
        PUSH_PLOT_ERR: begin
          push_beat.last  = 1'b1;
          push_beat.error = 1'b1;
        end
        default: push_beat = '0;
      endcase
    end
  end

  assign q_push    = pend_r || cmd.push;
  assign out_valid = (q_cnt_r != 2'd0);
  assign q_pop     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_wp_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (q_push) begin
        q_wp_r <= ~q_wp_r;
      end
      if (q_pop) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + 2'(q_push) - 2'(q_pop);
    end
  end

  assign out_half      = q_mem[q_rp_r].half;
  assign out_page      = q_mem[q_rp_r].page;
  assign out_column    = q_mem[q_rp_r].column;
  assign out_data      = q_mem[q_rp_r].data;
  assign out_last      = q_mem[q_rp_r].last;
  assign out_cmd_error = q_mem[q_rp_r].error;

  // A read issued now lands in the queue next cycle; keep room for it.
  assign q_level = 3'(q_cnt_r) + 3'(pend_r) - 3'(q_pop);

  assign stat.pix_ok         = (9'(px_r) < 9'(SCREEN_COLUMNS)) &&
                               (7'(py_r) < 7'(SCREEN_ROWS));
  assign stat.code_ok        = code_valid(code_r);
  assign stat.plot_ok        = plot_ok_r;
  assign stat.glyph_last     = (cnt_r == AW'(GLYPH_WIDTH - 1));
  assign stat.refresh_issued = (cnt_r == AW'(HALF_COLUMNS));
  assign stat.clear_last     = (cnt_r == AW'(DEPTH - 1));
  assign stat.q_space        = (q_cnt_r != 2'd2) || q_pop;
  assign stat.rd_credit      = (q_level <= 3'd1);
  assign stat.rd_pending     = pend_r;

  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_cnt_r != 2'd2 || q_pop))
    else $error("output queue overflow");

  a_single_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && cmd.push))
    else $error("refresh beat collided with a sequencer beat");

  a_refresh_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en && cmd.rd_sel == RD_REFRESH) |=> pend_r)
    else $error("refresh read lost from the pipeline");

endmodule

`default_nettype wire

### hw/rtl/mono_glcd_frame_controller.sv
// Top level of the monochrome graphic LCD frame controller: APB-style
// configuration registers plus mglcd_ctrl and mglcd_dp (types from mglcd_pkg).
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   req_type, pixel_x/y, text_char,
//                                              sample_value, target_*
//   out_      output     out_valid / out_stall half, page, column, data, last,
//                                              cmd_error
//   cfg_      input      psel/penable/pwrite   gain_tenths @0, offset_tenths @4
//
// After reset a clearing sweep zeroes all SCREEN_COLUMNS*8 store bytes (1024
// by default) before the first command is taken; clear screen runs the same
// sweep. Refresh emits 64 beats at one per cycle, while the output queue has
// room, out of the single store read port; put char emits GLYPH_WIDTH beats
// for a valid code; plot is staged in product, sum and quotient registers.
// A stalled output holds the sequencer once the two-beat output queue is full.
`default_nettype none

module mono_glcd_frame_controller
  import mglcd_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 64,
  parameter int GLYPH_WIDTH    = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [6:0]  in_pixel_x,
  input  wire logic [5:0]  in_pixel_y,
  input  wire logic [7:0]  in_text_char,
  input  wire logic [7:0]  in_sample_value,
  input  wire logic [2:0]  in_target_page,
  input  wire logic        in_target_half,
  input  wire logic [5:0]  in_target_column,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_half,
  output logic [2:0]       out_page,
  output logic [5:0]       out_column,
  output logic [7:0]       out_data,
  output logic             out_last,
  output logic             out_cmd_error,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  logic [7:0]  gain_r, offset_r;
  logic        cfg_wr;
  mglcd_cmd_t  cmd;
  mglcd_stat_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= 8'd10;
      offset_r <= 8'd10;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_GAIN) begin
        gain_r <= cfg_pwdata[7:0];
      end else begin
        offset_r <= cfg_pwdata[7:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_OFFSET) ? {24'd0, offset_r} : {24'd0, gain_r};

  mglcd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd)
  );

  mglcd_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .GLYPH_WIDTH    (GLYPH_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_text_char     (in_text_char),
    .in_sample_value  (in_sample_value),
    .in_target_page   (in_target_page),
    .in_target_half   (in_target_half),
    .in_target_column (in_target_column),
    .gain_tenths      (gain_r),
    .offset_tenths    (offset_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_half         (out_half),
    .out_page         (out_page),
    .out_column       (out_column),
    .out_data         (out_data),
    .out_last         (out_last),
    .out_cmd_error    (out_cmd_error)
  );

endmodule

`default_nettype wire
